// ----- sv/tfvp_pkg.sv -----
// ----------------------------------------------------------------------------
// tfvp_pkg - shared types and constants for the fan voltage policy core
// Opcodes, queue command format, configuration and constants used by the
// front, queue, back and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tfvp_pkg;

   // Default table depths
   localparam int CODE_DEPTH_DEF  = 256;
   localparam int CURVE_DEPTH_DEF = 112;

   // Input opcodes (tuser)
   localparam logic [2:0] OP_LOAD_CPU_TEMP  = 3'd0;
   localparam logic [2:0] OP_LOAD_SUP_TEMP  = 3'd1;
   localparam logic [2:0] OP_LOAD_CPU_CURVE = 3'd2;
   localparam logic [2:0] OP_LOAD_SUP_CURVE = 3'd3;
   localparam logic [2:0] OP_CPU_SAMPLE     = 3'd4;
   localparam logic [2:0] OP_SUP_SAMPLE     = 3'd5;
   localparam logic [2:0] OP_ROUND_END      = 3'd6;

   // Configuration register indexes
   localparam logic [1:0] CSR_FLOOR   = 2'd0;
   localparam logic [1:0] CSR_CEILING = 2'd1;
   localparam logic [1:0] CSR_ABSENT  = 2'd2;

   localparam logic [5:0] FLOOR_RST   = 6'd0;
   localparam logic [5:0] CEILING_RST = 6'd63;
   localparam logic [7:0] ABSENT_RST  = 8'd1;

   localparam logic [7:0] SUPPLY_OK_BITS = 8'h38;
   localparam logic [7:0] FANS_ALL_OK    = 8'hFF;

   // Peak / 1000000 as multiply by ceil(2^50 / 1e6), then shift by 50.
   // Exact for every non-negative 31-bit peak.
   localparam int          RECIP_SHIFT = 50;
   localparam int          PROD_W      = 62;
   localparam int          QUOT_W      = 12;
   localparam logic [30:0] RECIP_MULT  = 31'd1125899907;

   localparam logic [QUOT_W-1:0] CPU_OFFSET    = 12'd20;
   localparam logic [QUOT_W-1:0] SUPPLY_OFFSET = 12'd30;

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   typedef enum logic [2:0] {
      CMD_LOAD_CPU_TEMP,
      CMD_LOAD_SUP_TEMP,
      CMD_LOAD_CPU_CURVE,
      CMD_LOAD_SUP_CURVE,
      CMD_CPU_SAMPLE,
      CMD_SUP_SAMPLE,
      CMD_ROUND_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   addr;           // load index, or clamped sample code
      logic [31:0]  value;          // table entry
      logic         temp_ok;
      logic         supply_fail;    // ok bits not all set
      logic         fans_all_ok;
      logic         status_ok;
      logic [3:0]   fan_fail_count;
   } cmd_type;

   typedef struct packed {
      logic [5:0] floor_v;
      logic [5:0] ceiling_v;
      logic [7:0] absent_mask;
   } cfg_type;

   typedef struct packed {
      logic       fan_count_valid;
      logic [3:0] fan_fail_count;
      logic [1:0] supply_fail_count;
      logic [5:0] supply_fan_voltage;
      logic [5:0] cpu_fan_voltage;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/thermal_fan_voltage_policy_core.sv -----
// A round-end beat passes the queue, the stage 2, 3 and 4 registers and the output register.
// Throughput: table loads and samples go 1 beat per cycle through the back end unless a round
//   end is in flight; a round end holds the issue through divide multiply, curve read and clamp.
// The front keeps accepting into a 4-entry command queue while results wait at rsp_.
// Reset: synchronous, active high; clears queue, pipeline valids, peaks, failure count and
//   config registers. Tables are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// thermal_fan_voltage_policy_core - fan voltage policy for one polling round
// Front decodes beats into a command queue; back owns the four tables, the
// peak/failure accumulators and the round-end voltage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_fan_voltage_policy_core import tfvp_pkg::*; #(
   parameter int CODE_TABLE_DEPTH  = CODE_DEPTH_DEF,   // 16..256
   parameter int CURVE_TABLE_DEPTH = CURVE_DEPTH_DEF   // 16..256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request beats
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [2:0]  req_tuser,   // [2:0] opcode
   // [7:0] entry_index, [39:8] entry_value, [47:40] raw_code,
   // [55:48] status_byte, [56] status_ok, [57] temp_ok, [63:58] zero
   input  wire logic [63:0] req_tdata,
   // result beats
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [5:0] cpu_fan_voltage, [11:6] supply_fan_voltage, [13:12] supply_fail_count,
   // [17:14] fan_fail_count, [18] fan_count_valid, [23:19] zero
   output logic [23:0]      rsp_tdata,
   // register writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   // config registers
   logic [5:0] floor_ff, floor_in;
   logic [5:0] ceiling_ff, ceiling_in;
   logic [7:0] absent_ff, absent_in;
   cfg_type    cfg;

   // front/queue/back links
   logic       q_push;
   cmd_type    q_push_cmd;
   logic       q_pop;
   logic       q_full;
   logic       q_empty;
   cmd_type    q_head;
   result_type rsp_data;

   always_comb begin
      floor_in   = floor_ff;
      ceiling_in = ceiling_ff;
      absent_in  = absent_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FLOOR:   floor_in   = csr_wdata[5:0];
            CSR_CEILING: ceiling_in = csr_wdata[5:0];
            CSR_ABSENT:  absent_in  = csr_wdata;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= FLOOR_RST;
         ceiling_ff <= CEILING_RST;
         absent_ff  <= ABSENT_RST;
      end else begin
         floor_ff   <= floor_in;
         ceiling_ff <= ceiling_in;
         absent_ff  <= absent_in;
      end
   end

   assign cfg.floor_v     = floor_ff;
   assign cfg.ceiling_v   = ceiling_ff;
   assign cfg.absent_mask = absent_ff;

   // decode and filter beats
   tfvp_front #(
      .CODE_DEPTH  (CODE_TABLE_DEPTH),
      .CURVE_DEPTH (CURVE_TABLE_DEPTH)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_push_cmd)
   );

   // decouples front from back-end stalls
   tfvp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_cmd (q_head)
   );

   // tables, accumulators, round-end pipeline and output register
   tfvp_back #(
      .CODE_DEPTH  (CODE_TABLE_DEPTH),
      .CURVE_DEPTH (CURVE_TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_cmd      (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {5'd0, rsp_data.fan_count_valid, rsp_data.fan_fail_count,
                       rsp_data.supply_fail_count, rsp_data.supply_fan_voltage,
                       rsp_data.cpu_fan_voltage};

endmodule

`default_nettype wire

// ----- sv/tfvp_front.sv -----
// ----------------------------------------------------------------------------
// tfvp_front - input beat decode and classification
// Unpacks the request beat, drops beats with no effect and builds a queue
// command with the per-beat status work already done.
// ----------------------------------------------------------------------------
`default_nettype none

module tfvp_front import tfvp_pkg::*; #(
   parameter int CODE_DEPTH  = CODE_DEPTH_DEF,
   parameter int CURVE_DEPTH = CURVE_DEPTH_DEF
) (
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [2:0]  req_tuser,
   input  wire logic [63:0] req_tdata,
   input  wire cfg_type     cfg,
   input  wire logic        q_full,
   output logic             q_push,
   output cmd_type          q_cmd
);

   logic [7:0]  entry_index;
   logic [31:0] entry_value;
   logic [7:0]  raw_code;
   logic [7:0]  status_byte;
   logic        status_ok;
   logic        temp_ok;
   logic [7:0]  code_clamped;
   logic        code_idx_ok;
   logic        curve_idx_ok;
   logic        keep;

   assign entry_index = req_tdata[7:0];
   assign entry_value = req_tdata[39:8];
   assign raw_code    = req_tdata[47:40];
   assign status_byte = req_tdata[55:48];
   assign status_ok   = req_tdata[56];
   assign temp_ok     = req_tdata[57];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && keep;

   assign code_idx_ok  = {1'b0, entry_index} < 9'(CODE_DEPTH);
   assign curve_idx_ok = {1'b0, entry_index} < 9'(CURVE_DEPTH);
   // codes past the table end read the last entry
   assign code_clamped = ({1'b0, raw_code} >= 9'(CODE_DEPTH)) ? 8'(CODE_DEPTH - 1) : raw_code;

   always_comb begin
      q_cmd                = '0;
      q_cmd.kind           = CMD_ROUND_END;
      q_cmd.addr           = entry_index;
      q_cmd.value          = entry_value;
      q_cmd.temp_ok        = temp_ok;
      q_cmd.supply_fail    = (status_byte & SUPPLY_OK_BITS) != SUPPLY_OK_BITS;
      q_cmd.fans_all_ok    = status_ok && (status_byte == FANS_ALL_OK);
      q_cmd.status_ok      = status_ok;
      q_cmd.fan_fail_count = status_ok ? 4'($countones(~status_byte)) : 4'd0;
      keep                 = 1'b0;
      unique case (req_tuser)
         OP_LOAD_CPU_TEMP: begin
            q_cmd.kind = CMD_LOAD_CPU_TEMP;
            keep       = code_idx_ok;
         end
         OP_LOAD_SUP_TEMP: begin
            q_cmd.kind = CMD_LOAD_SUP_TEMP;
            keep       = code_idx_ok;
         end
         OP_LOAD_CPU_CURVE: begin
            q_cmd.kind = CMD_LOAD_CPU_CURVE;
            keep       = curve_idx_ok;
         end
         OP_LOAD_SUP_CURVE: begin
            q_cmd.kind = CMD_LOAD_SUP_CURVE;
            keep       = curve_idx_ok;
         end
         OP_CPU_SAMPLE: begin
            q_cmd.kind = CMD_CPU_SAMPLE;
            q_cmd.addr = code_clamped;
            keep       = 1'b1;
         end
         OP_SUP_SAMPLE: begin
            // unread status means absent
            q_cmd.kind = CMD_SUP_SAMPLE;
            q_cmd.addr = code_clamped;
            keep       = status_ok && ((status_byte & cfg.absent_mask) == 8'd0);
         end
         OP_ROUND_END: begin
            q_cmd.kind = CMD_ROUND_END;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/tfvp_queue.sv -----
// ----------------------------------------------------------------------------
// tfvp_queue - command queue between front and back
// Small FIFO of decoded commands; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tfvp_queue import tfvp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output cmd_type      head_cmd
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full     = count_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tfvp_back.sv -----
// ----------------------------------------------------------------------------
// tfvp_back - table storage, accumulators and round-end voltage pipeline
// Issue: table write or code table read. S2: peak and failure update, or
// round-end snapshot and divide multiply. S3: curve index and curve read.
// S4: floor/ceiling clamp into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfvp_back import tfvp_pkg::*; #(
   parameter int CODE_DEPTH  = CODE_DEPTH_DEF,
   parameter int CURVE_DEPTH = CURVE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    q_empty,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output result_type   rsp_data
);

   localparam int CODE_AW  = $clog2(CODE_DEPTH);
   localparam int CURVE_AW = $clog2(CURVE_DEPTH);

   typedef struct packed {
      logic       cpu_force;
      logic       sup_force;
      logic [1:0] supply_fail_count;
      logic [3:0] fan_fail_count;
      logic       fan_count_valid;
   } round_meta_type;

   // table storage, undefined until loaded
   logic [31:0] cpu_temp_mem  [CODE_DEPTH];
   logic [31:0] sup_temp_mem  [CODE_DEPTH];
   logic [5:0]  cpu_curve_mem [CURVE_DEPTH];
   logic [5:0]  sup_curve_mem [CURVE_DEPTH];

   logic [CODE_AW-1:0] code_addr;
   logic [CURVE_AW-1:0] curve_waddr;

   // stage 2
   logic         s2_valid_ff, s2_valid_in;
   cmd_type      s2_cmd_ff;
   logic signed [31:0] cpu_rd_ff;
   logic signed [31:0] sup_rd_ff;

   // accumulators
   logic signed [31:0] cpu_peak_ff, cpu_peak_in;
   logic signed [31:0] sup_peak_ff, sup_peak_in;
   logic [1:0]         fails_ff, fails_in;
   logic signed [31:0] cpu_t;
   logic signed [31:0] sup_t;

   // stage 3
   logic                s3_valid_ff, s3_valid_in;
   round_meta_type      s3_meta_ff, s3_meta_in;
   logic [PROD_W-1:0]   cpu_prod_ff, cpu_prod_in;
   logic [PROD_W-1:0]   sup_prod_ff, sup_prod_in;
   logic [30:0]         cpu_pos;
   logic [30:0]         sup_pos;
   logic [QUOT_W-1:0]   cpu_quot;
   logic [QUOT_W-1:0]   sup_quot;
   logic [CURVE_AW-1:0] cpu_cidx;
   logic [CURVE_AW-1:0] sup_cidx;

   // stage 4
   logic           s4_valid_ff, s4_valid_in;
   round_meta_type s4_meta_ff;
   logic [5:0]     cpu_curve_rd_ff;
   logic [5:0]     sup_curve_rd_ff;
   logic [5:0]     cpu_volt;
   logic [5:0]     sup_volt;

   // output register
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   logic       out_load;

   logic round_busy;
   logic s2_round;

   function automatic logic [CURVE_AW-1:0] curve_index(input logic [QUOT_W-1:0] q,
                                                       input logic [QUOT_W-1:0] off);
      logic [QUOT_W-1:0] d;
      begin
         d = q - off;
         if (q < off) begin
            curve_index = '0;
         end else if (d > QUOT_W'(CURVE_DEPTH - 1)) begin
            curve_index = CURVE_AW'(CURVE_DEPTH - 1);
         end else begin
            curve_index = d[CURVE_AW-1:0];
         end
      end
   endfunction

   function automatic logic [5:0] clamp_volt(input logic [5:0] v, input logic force_max,
                                             input cfg_type c);
      begin
         if (force_max) begin
            clamp_volt = c.ceiling_v;
         end else if (v < c.floor_v) begin
            clamp_volt = c.floor_v;
         end else if (v > c.ceiling_v) begin
            clamp_volt = c.ceiling_v;
         end else begin
            clamp_volt = v;
         end
      end
   endfunction

   // ---------------- issue ----------------
   assign s2_round   = s2_valid_ff && (s2_cmd_ff.kind == CMD_ROUND_END);
   // one round end in flight; later loads wait so curve reads see old data
   assign round_busy = s2_round || s3_valid_ff || s4_valid_ff;
   assign q_pop      = !q_empty && !round_busy;
   assign code_addr  = q_cmd.addr[CODE_AW-1:0];
   assign curve_waddr = q_cmd.addr[CURVE_AW-1:0];
   assign s2_valid_in = q_pop;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         case (q_cmd.kind)
            CMD_LOAD_CPU_TEMP:  cpu_temp_mem[code_addr] <= q_cmd.value;
            CMD_LOAD_SUP_TEMP:  sup_temp_mem[code_addr] <= q_cmd.value;
            CMD_LOAD_CPU_CURVE: cpu_curve_mem[curve_waddr] <= q_cmd.value[5:0];
            CMD_LOAD_SUP_CURVE: sup_curve_mem[curve_waddr] <= q_cmd.value[5:0];
            default: ;
         endcase
         cpu_rd_ff <= cpu_temp_mem[code_addr];
         sup_rd_ff <= sup_temp_mem[code_addr];
         s2_cmd_ff <= q_cmd;
      end
   end

   // ---------------- stage 2 ----------------
   assign cpu_t   = s2_cmd_ff.temp_ok ? cpu_rd_ff : -32'sd1;
   assign sup_t   = s2_cmd_ff.temp_ok ? sup_rd_ff : -32'sd1;
   assign cpu_pos = cpu_peak_ff[31] ? 31'd0 : cpu_peak_ff[30:0];
   assign sup_pos = sup_peak_ff[31] ? 31'd0 : sup_peak_ff[30:0];

   always_comb begin
      cpu_peak_in = cpu_peak_ff;
      sup_peak_in = sup_peak_ff;
      fails_in    = fails_ff;
      s3_valid_in = s2_round;
      cpu_prod_in = PROD_W'(cpu_pos) * PROD_W'(RECIP_MULT);
      sup_prod_in = PROD_W'(sup_pos) * PROD_W'(RECIP_MULT);
      s3_meta_in.cpu_force         = (cpu_peak_ff == -32'sd1) || !s2_cmd_ff.fans_all_ok;
      s3_meta_in.sup_force         = (sup_peak_ff == -32'sd1) || !s2_cmd_ff.fans_all_ok;
      s3_meta_in.supply_fail_count = fails_ff;
      s3_meta_in.fan_fail_count    = s2_cmd_ff.fan_fail_count;
      s3_meta_in.fan_count_valid   = s2_cmd_ff.status_ok;
      if (s2_valid_ff) begin
         case (s2_cmd_ff.kind)
            CMD_CPU_SAMPLE: begin
               if (cpu_t != -32'sd1 && cpu_peak_ff < cpu_t) begin
                  cpu_peak_in = cpu_t;
               end
            end
            CMD_SUP_SAMPLE: begin
               if (s2_cmd_ff.supply_fail && fails_ff != 2'd3) begin
                  fails_in = fails_ff + 2'd1;
               end
               if (sup_peak_ff < sup_t) begin
                  sup_peak_in = sup_t;
               end
            end
            CMD_ROUND_END: begin
               cpu_peak_in = -32'sd1;
               sup_peak_in = -32'sd1;
               fails_in    = 2'd0;
            end
            default: ;
         endcase
      end
   end

   // ---------------- stage 3 ----------------
   assign cpu_quot    = cpu_prod_ff[PROD_W-1:RECIP_SHIFT];
   assign sup_quot    = sup_prod_ff[PROD_W-1:RECIP_SHIFT];
   assign cpu_cidx    = curve_index(cpu_quot, CPU_OFFSET);
   assign sup_cidx    = curve_index(sup_quot, SUPPLY_OFFSET);
   assign s4_valid_in = s3_valid_ff || (s4_valid_ff && !out_load);

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         cpu_curve_rd_ff <= cpu_curve_mem[cpu_cidx];
         sup_curve_rd_ff <= sup_curve_mem[sup_cidx];
         s4_meta_ff      <= s3_meta_ff;
      end
   end

   // ---------------- stage 4 ----------------
   assign cpu_volt     = clamp_volt(cpu_curve_rd_ff, s4_meta_ff.cpu_force, cfg);
   assign sup_volt     = clamp_volt(sup_curve_rd_ff, s4_meta_ff.sup_force, cfg);
   assign out_load     = s4_valid_ff && (!out_valid_ff || rsp_tready);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff.cpu_fan_voltage    <= cpu_volt;
         out_data_ff.supply_fan_voltage <= sup_volt;
         out_data_ff.supply_fail_count  <= s4_meta_ff.supply_fail_count;
         out_data_ff.fan_fail_count     <= s4_meta_ff.fan_fail_count;
         out_data_ff.fan_count_valid    <= s4_meta_ff.fan_count_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_round) begin
         cpu_prod_ff <= cpu_prod_in;
         sup_prod_ff <= sup_prod_in;
         s3_meta_ff  <= s3_meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cpu_peak_ff  <= -32'sd1;
         sup_peak_ff  <= -32'sd1;
         fails_ff     <= 2'd0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         out_valid_ff <= out_valid_in;
         cpu_peak_ff  <= cpu_peak_in;
         sup_peak_ff  <= sup_peak_in;
         fails_ff     <= fails_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_data_ff;

endmodule

`default_nettype wire

// ----- sv/tfvp_checker.sv -----
// ----------------------------------------------------------------------------
// tfvp_checker - port-level checks for the fan voltage policy core
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tfvp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // unread fan status reports no failed fans
   a_fan_cnt_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[18] |-> rsp_tdata[17:14] == 4'd0)
      else $error("fan fail count set without valid fan status");

   // at most eight fans
   a_fan_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:14] <= 4'd8)
      else $error("fan fail count out of range");

   // any failed fan forces both voltages to the ceiling; checked as equal voltages
   a_fan_fail_force: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18] && rsp_tdata[17:14] != 4'd0
         |-> rsp_tdata[5:0] == rsp_tdata[11:6])
      else $error("fan failure did not force both fan voltages");

   // pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:19] == 5'd0)
      else $error("result pad bits not zero");

endmodule

bind thermal_fan_voltage_policy_core tfvp_checker u_tfvp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
